/* rtl/core/pfv_pkg.sv */
// Shared constants for the snorm 11:11:10 vector packing pipeline.
// No dependencies; the interfaces, unit and lane refer to it by scoped names, the testbench imports it.
package pfv_pkg;

   localparam int unsigned FLOAT_W    = 32;
   localparam int unsigned MANT_W     = 23;
   localparam int unsigned EXP_W      = 8;
   localparam int unsigned SIG_W      = MANT_W + 1;
   localparam int unsigned EXP_BIAS   = 127;
   localparam int unsigned EXP_OFFSET = 151;
   localparam int unsigned SHIFT_W    = 8;
   localparam int unsigned XY_FIELD_W = 11;
   localparam int unsigned Z_FIELD_W  = 10;
   localparam int unsigned WORD_W     = 2 * XY_FIELD_W + Z_FIELD_W;

endpackage

/* rtl/core/pfv_if.sv */
// Valid/ready channel interfaces for the request and response sides.
// Depends on pfv_pkg for the payload widths.
interface pfv_req_if;
   logic                          valid;
   logic                          ready;
   logic [pfv_pkg::FLOAT_W-1:0]   x_float;
   logic [pfv_pkg::FLOAT_W-1:0]   y_float;
   logic [pfv_pkg::FLOAT_W-1:0]   z_float;

   modport source (output valid, output x_float, output y_float, output z_float,
                   input ready);
   modport sink   (input valid, input x_float, input y_float, input z_float,
                   output ready);
endinterface

interface pfv_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pfv_pkg::WORD_W-1:0]    packed_word;

   modport source (output valid, output packed_word, input ready);
   modport sink   (input valid, input packed_word, output ready);
endinterface

/* rtl/core/pack_float_vector_snorm_11_11_10_unit.sv */
// Packs three single-precision components into one signed-normalized 11:11:10 word.
// One transaction enters per cycle while the response side does not stall; the
// result passes through the three lane stages (decode and multiply, round,
// floor and pack). A stall on the response side holds every stage in place.
// Depends on pfv_pkg, pfv_if and pfv_lane.
module pack_float_vector_snorm_11_11_10_unit (
   input  logic           clock,
   input  logic           reset,
   pfv_req_if.sink        req_if,
   pfv_rsp_if.source      rsp_if
);

   logic en;
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic [pfv_pkg::XY_FIELD_W-1:0] fx, fy;
   logic [pfv_pkg::Z_FIELD_W-1:0]  fz;

   // advance the whole pipe unless the result register is held
   assign en           = !v3_ff || rsp_if.ready;
   assign req_if.ready = en;

   assign v1_in = en ? req_if.valid : v1_ff;
   assign v2_in = en ? v1_ff : v2_ff;
   assign v3_in = en ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   pfv_lane #(.FIELD_W(pfv_pkg::XY_FIELD_W)) u_lane_x (
      .clock(clock), .en(en), .comp_bits(req_if.x_float), .field_out(fx));
   pfv_lane #(.FIELD_W(pfv_pkg::XY_FIELD_W)) u_lane_y (
      .clock(clock), .en(en), .comp_bits(req_if.y_float), .field_out(fy));
   pfv_lane #(.FIELD_W(pfv_pkg::Z_FIELD_W)) u_lane_z (
      .clock(clock), .en(en), .comp_bits(req_if.z_float), .field_out(fz));

   assign rsp_if.valid       = v3_ff;
   assign rsp_if.packed_word = {fz, fy, fx};

`ifndef ASSERT_OFF
   // an accepted transaction shows up in the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> v1_ff)
      else $error("accepted transaction missing from stage 1");
   // a held stage keeps its valid bits
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!en && v2_ff) |=> v2_ff && v3_ff)
      else $error("stalled pipeline dropped a transaction");
   // stage 2 moves into the result register on advance
   a_move: assert property (@(posedge clock) disable iff (reset)
      (en && v2_ff) |=> rsp_if.valid)
      else $error("stage 2 transaction lost on advance");
`endif

endmodule

/* rtl/core/pfv_lane.sv */
// One component lane: decode and scale, round to single, floor and truncate.
// Three register stages advanced by a common enable. Depends on pfv_pkg.
module pfv_lane #(
   parameter int unsigned FIELD_W = pfv_pkg::XY_FIELD_W
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [pfv_pkg::FLOAT_W-1:0] comp_bits,
   output logic [FIELD_W-1:0]          field_out
);

   localparam int unsigned SIG_W = pfv_pkg::SIG_W;
   localparam int unsigned NW    = SIG_W + FIELD_W;
   localparam int unsigned MUL2  = (1 << FIELD_W) - 1;
   localparam int unsigned SH_W  = pfv_pkg::SHIFT_W;
   localparam int unsigned EW    = pfv_pkg::EXP_W;

   // stage 1: decode, clamp, multiply
   logic [EW-1:0]                 expo;
   logic [pfv_pkg::MANT_W-1:0]    frac;
   logic                          clamp;
   logic [EW-1:0]                 expo_c;
   logic [pfv_pkg::MANT_W-1:0]    frac_c;
   logic [NW-1:0]                 n1_in, n1_ff;
   logic [EW-1:0]                 e1_in, e1_ff;
   logic                          neg1_ff, kill1_in, kill1_ff, sub1_in, sub1_ff;

   always_comb begin
      expo     = comp_bits[pfv_pkg::FLOAT_W-2:pfv_pkg::MANT_W];
      frac     = comp_bits[pfv_pkg::MANT_W-1:0];
      clamp    = (expo >= EW'(pfv_pkg::EXP_BIAS));
      expo_c   = clamp ? EW'(pfv_pkg::EXP_BIAS) : expo;
      frac_c   = clamp ? '0 : frac;
      kill1_in = ((&expo) && (frac != '0)) || (expo_c == '0 && frac_c == '0);
      sub1_in  = (expo_c == '0) && (frac_c != '0);
      e1_in    = expo_c;
      n1_in    = NW'({1'b1, frac_c}) * NW'(MUL2);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff    <= n1_in;
         e1_ff    <= e1_in;
         neg1_ff  <= comp_bits[pfv_pkg::FLOAT_W-1];
         kill1_ff <= kill1_in;
         sub1_ff  <= sub1_in;
      end
   end

   // stage 2: round to 24 significant bits, nearest even
   logic          top;
   logic [NW-1:0] m;
   logic [SIG_W-1:0] q0;
   logic [FIELD_W-1:0] rem;
   logic [FIELD_W-1:0] half;
   logic          up;
   logic [SIG_W:0] qr;
   logic [SIG_W-1:0] q2_in, q2_ff;
   logic [SH_W:0] s;
   logic [SH_W-1:0] sh2_in, sh2_ff;
   logic          neg2_ff, kill2_ff, sub2_ff;

   always_comb begin
      top    = n1_ff[NW-1];
      m      = top ? n1_ff : (n1_ff << 1);
      q0     = m[NW-1:FIELD_W];
      rem    = m[FIELD_W-1:0];
      half   = FIELD_W'(1) << (FIELD_W - 1);
      up     = (rem > half) || ((rem == half) && q0[0]);
      qr     = {1'b0, q0} + (SIG_W+1)'(up);
      q2_in  = qr[SIG_W] ? (SIG_W'(1) << (SIG_W - 1)) : qr[SIG_W-1:0];
      s      = (top ? (SH_W+1)'(FIELD_W) : (SH_W+1)'(FIELD_W - 1)) + (SH_W+1)'(qr[SIG_W]);
      sh2_in = SH_W'((SH_W+1)'(pfv_pkg::EXP_OFFSET) - (SH_W+1)'(e1_ff) - s);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q2_ff    <= q2_in;
         sh2_ff   <= sh2_in;
         neg2_ff  <= neg1_ff;
         kill2_ff <= kill1_ff;
         sub2_ff  <= sub1_ff;
      end
   end

   // stage 3: floor to integer, apply sign, keep low bits
   logic [SIG_W-1:0]   mask;
   logic [FIELD_W-1:0] ip;
   logic               fr;
   logic [FIELD_W-1:0] field_in, field_ff;

   always_comb begin
      mask = (SIG_W'(1) << sh2_ff) - SIG_W'(1);
      ip   = FIELD_W'(q2_ff >> sh2_ff);
      fr   = (q2_ff & mask) != '0;
      if (kill2_ff) begin
         field_in = '0;
      end else if (sub2_ff) begin
         field_in = neg2_ff ? '1 : '0;
      end else if (neg2_ff) begin
         field_in = FIELD_W'(0) - ip - FIELD_W'(fr);
      end else begin
         field_in = ip;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         field_ff <= field_in;
      end
   end

   assign field_out = field_ff;

endmodule

/* tb/pack_float_vector_snorm_11_11_10_unit_tb_if.sv */
// Testbench constants: corner-case float bit patterns and the doubled scale factors.
// No dependencies; the testbench top refers to this package.
`timescale 1ns / 100ps
package pfv_tb_pkg;
   localparam logic [31:0] POS_ONE  = 32'h3F80_0000;
   localparam logic [31:0] NEG_ONE  = 32'hBF80_0000;
   localparam logic [31:0] POS_INF  = 32'h7F80_0000;
   localparam logic [31:0] NEG_INF  = 32'hFF80_0000;
   localparam logic [31:0] QNAN     = 32'h7FC0_0000;
   localparam logic [31:0] NEG_ZERO = 32'h8000_0000;
   localparam int unsigned XY_MUL2  = 2047;
   localparam int unsigned Z_MUL2   = 1023;
endpackage

/* tb/pack_float_vector_snorm_11_11_10_unit_tb.sv */
// Self-checking testbench for the snorm 11:11:10 vector packing unit.
// Drives random and corner-case float triples, predicts the packed word, checks it.
// Depends on pfv_pkg, pfv_if, pfv_tb_pkg and the unit under test.
`timescale 1ns / 100ps
module pack_float_vector_snorm_11_11_10_unit_tb;
   import pfv_pkg::*;
   import pfv_tb_pkg::*;

   // Convert one float bit pattern to its snorm integer; mul2 is twice the scale.
   function automatic logic [31:0] snorm_of(logic [31:0] bits, int unsigned mul2);
      logic [7:0]  expo;
      logic [22:0] frac;
      logic        neg;
      logic [63:0] prod, q, rem, half;
      int          t, len, s, sh;
      logic [31:0] ip;
      logic        fr;
      expo = bits[30:23];
      frac = bits[22:0];
      neg  = bits[31];
      if (expo == 8'hFF && frac != 0) return 0;
      if (expo >= 8'd127) begin
         expo = 8'd127;
         frac = 0;
      end
      if (expo == 0 && frac == 0) return 0;
      prod = 64'({(expo != 0), frac}) * 64'(mul2);
      t = ((expo != 0) ? int'(expo) : 1) - 151;
      len = 0;
      while (len < 64 && (prod >> len) != 0) len++;
      s = 0;
      q = prod;
      if (len > 24) begin
         s = len - 24;
         q = prod >> s;
         rem = prod & ((64'd1 << s) - 1);
         half = 64'd1 << (s - 1);
         if (rem > half || (rem == half && q[0])) q++;
         if (q == (64'd1 << 24)) begin
            q = q >> 1;
            s++;
         end
      end
      t += s;
      if (t >= 0) begin
         ip = (t < 32) ? 32'(q << t) : 0;
         fr = 0;
      end else begin
         sh = -t;
         if (sh >= 64) begin
            ip = 0;
            fr = 1;
         end else begin
            ip = 32'(q >> sh);
            fr = (q & ((64'd1 << sh) - 1)) != 0;
         end
      end
      if (!neg) return ip;
      return (32'd0 - ip) - (fr ? 32'd1 : 32'd0);
   endfunction

   // Hold the expected packed words in arrival order and compare results.
   class packed_word_board;
      logic [WORD_W-1:0] pending[$];
      int                errors = 0;

      function void note_vector(logic [31:0] xf, logic [31:0] yf, logic [31:0] zf);
         logic [31:0] cx, cy, cz;
         cx = snorm_of(xf, XY_MUL2);
         cy = snorm_of(yf, XY_MUL2);
         cz = snorm_of(zf, Z_MUL2);
         pending.push_back({cz[9:0], cy[10:0], cx[10:0]});
      endfunction

      function void check_word(logic [WORD_W-1:0] got);
         logic [WORD_W-1:0] want;
         if (pending.size() == 0) begin
            $error("packed_word: unexpected result %h", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $error("packed_word: expected %h, actual %h", want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   pfv_req_if req_if ();
   pfv_rsp_if rsp_if ();

   pack_float_vector_snorm_11_11_10_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   packed_word_board board = new();
   bit  calm;            // set during the stretch with no idling on either side
   int  idle_cycles = 0; // cycles since the last transaction on either channel
   localparam int WATCHDOG_LIMIT = 2000;

   // Pick a float with a bias toward interesting exponents.
   function automatic logic [31:0] pick_float();
      logic [31:0] f;
      f = $urandom;
      case ($urandom_range(0, 9))
         0:       f[30:23] = 8'hFF;
         1:       f[30:23] = 8'h00;
         2, 3:    f[30:23] = 8'(126 - $urandom_range(0, 3));
         4:       f[30:23] = 8'd127;
         5, 6, 7: f[30:23] = 8'($urandom_range(100, 126));
         default: ;
      endcase
      return f;
   endfunction

   // Offer one transaction and hold it until accepted; idle first at random.
   task automatic send_vector(logic [31:0] xf, logic [31:0] yf, logic [31:0] zf);
      while (!calm && $urandom_range(0, 99) < 29) begin
         req_if.valid <= 0;
         @(negedge clock);
      end
      req_if.valid   <= 1;
      req_if.x_float <= xf;
      req_if.y_float <= yf;
      req_if.z_float <= zf;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_vector(xf, yf, zf);
      @(negedge clock);
   endtask

   // Random ready on the response side; sample results at the rising edge.
   always @(negedge clock)
      rsp_if.ready <= reset ? 1'b0 : (calm || $urandom_range(0, 99) >= 29);

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) board.check_word(rsp_if.packed_word);
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("pack_float_vector_snorm_11_11_10_unit_tb failed");
         $finish;
      end
   end

   task automatic drain();
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   initial begin
      logic [31:0] corners[$];
      req_if.valid   = 0;
      req_if.x_float = 0;
      req_if.y_float = 0;
      req_if.z_float = 0;
      rsp_if.ready   = 0;
      calm = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: zeros, unit values, infinities, NaNs, subnormals, all-ones.
      corners = '{32'h0, NEG_ZERO, POS_ONE, NEG_ONE, POS_INF, NEG_INF, QNAN,
                  32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF,
                  32'h807F_FFFF, 32'h3F7F_FFFF, 32'hBF7F_FFFF, 32'h3F00_0000,
                  32'hBF00_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3A80_0000,
                  32'hBA80_0000};
      foreach (corners[i])
         send_vector(corners[i], corners[(i + 7) % corners.size()],
                     corners[(i + 13) % corners.size()]);

      // Pause the sender until every result is back.
      req_if.valid <= 0;
      drain();

      for (int n = 0; n < 1500; n++) begin
         calm = (n >= 600 && n < 800);
         if (n == 1000) begin
            req_if.valid <= 0;
            drain();
            @(negedge clock);
         end
         send_vector(pick_float(), pick_float(), pick_float());
      end
      req_if.valid <= 0;
      calm = 0;
      drain();
      repeat (10) @(negedge clock);

      if (board.errors == 0 && board.pending.size() == 0)
         $display("pack_float_vector_snorm_11_11_10_unit_tb passed");
      else
         $display("pack_float_vector_snorm_11_11_10_unit_tb failed");
      $finish;
   end
endmodule
